// ===== design/sspr_pkg.sv =====
// Shared types and constants for the soft-start PWM ramp with stall detect.
// Holds the transaction payload structs, register indexes and field widths.
// No dependencies.
package sspr_pkg;

  localparam int unsigned DirW    = 2;
  localparam int unsigned DutyW   = 8;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned RampW   = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;

  localparam logic [DirW-1:0] DIR_STOP = 2'd0;

  localparam logic [CfgIdxW-1:0] REG_RAMP_TIME     = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_STALL_TIMEOUT = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_MIN_DUTY      = 2'd2;

  typedef struct packed {
    logic [DirW-1:0]  command_direction;
    logic [DutyW-1:0] target_duty;
    logic [TimeW-1:0] time_now_ms;
  } in_item_t;

  typedef struct packed {
    logic [DirW-1:0]  drive_direction;
    logic [DutyW-1:0] drive_duty;
    logic             stall_fault;
  } out_item_t;

endpackage

// ===== design/sspr_sub_unit.sv =====
// Shared 32-bit subtract/compare unit for the ramp sequencer.
// Gives a - b and the unsigned a >= b flag. Depends on sspr_pkg.
module sspr_sub_unit (
  input  logic [sspr_pkg::TimeW-1:0] op_a,
  input  logic [sspr_pkg::TimeW-1:0] op_b,
  output logic [sspr_pkg::TimeW-1:0] diff,
  output logic                       a_ge_b
);
  import sspr_pkg::*;

  logic [TimeW:0] sum_w;

  // a + ~b + 1: carry out set means no borrow
  assign sum_w  = {1'b0, op_a} + {1'b0, ~op_b} + {{TimeW{1'b0}}, 1'b1};
  assign diff   = sum_w[TimeW-1:0];
  assign a_ge_b = sum_w[TimeW];

endmodule

// ===== design/soft_start_pwm_ramp_stall_detect.sv =====
// Top level of the soft-start PWM ramp with stall timeout detection.
// Uses sspr_pkg and one shared subtract/compare unit (sspr_sub_unit).
//
// Channel  Direction  Handshake              Payload
// in_      input      in_valid / in_ready    in_data  (sspr_pkg::in_item_t)
// out_     output     out_valid / out_ready  out_data (sspr_pkg::out_item_t)
// cfg_     input      cfg_we                 cfg_index, cfg_wdata
//
// One transaction at a time. A stop command goes straight to the output step; a ramping
// command takes the elapsed time, compares it with the ramp time, divides only while
// ramping with a nonzero target, and checks the stall timer only at low duty. The
// restoring divide runs one quotient bit a cycle through the single subtract/compare
// unit, which also serves the elapsed, ramp, low-duty and stall compares. in_ready
// returns on the edge that loads the result. Reset (rst_n low, synchronous) loads the
// register defaults and clears the direction and time stamps. in_ready is high only while idle;
// a result held by out_ready low stalls the sequencer before it overwrites the output.
module soft_start_pwm_ramp_stall_detect (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  sspr_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output sspr_pkg::out_item_t          out_data,
  input  logic                         cfg_we,
  input  logic [sspr_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [sspr_pkg::CfgW-1:0]    cfg_wdata
);
  import sspr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,   // wait for a transaction
    S_ELAP,   // elapsed = now - ramp start
    S_RCMP,   // elapsed >= ramp time?
    S_MUL,    // product = target * elapsed
    S_DIV,    // one quotient bit a cycle
    S_LOWCMP, // duty <= min active level?
    S_SDIFF,  // now - stall stamp
    S_SCMP,   // stall time >= timeout?
    S_OUT     // load the output register
  } state_t;

  state_t state_r;

  // configuration
  logic [RampW-1:0] ramp_time_r;
  logic [RampW-1:0] timeout_r;
  logic [DutyW-1:0] min_duty_r;

  // persistent ramp state
  logic [DirW-1:0]  prev_dir_r;
  logic [TimeW-1:0] ramp_start_r;
  logic [TimeW-1:0] stamp_r;

  // per-transaction working registers
  in_item_t           item_r;
  logic [TimeW-1:0]   work_r;     // elapsed time, later stall time
  logic [DutyW-1:0]   prod_r;     // low product bits, shifted into the divide
  logic [RampW-1:0]   rem_r;
  logic [DutyW-1:0]   quot_r;
  logic [2:0]         cnt_r;
  logic [DutyW-1:0]   duty_r;
  logic               fault_r;

  out_item_t out_r;
  logic      out_valid_r;

  // shared unit operands
  logic [TimeW-1:0] op_a;
  logic [TimeW-1:0] op_b;
  logic [TimeW-1:0] sub_diff;
  logic             sub_ge;
  logic [23:0]      mul_w;

  sspr_sub_unit u_sub (
    .op_a   (op_a),
    .op_b   (op_b),
    .diff   (sub_diff),
    .a_ge_b (sub_ge)
  );

  // elapsed is below ramp time here, so 16 bits suffice
  assign mul_w = {16'b0, item_r.target_duty} * {8'b0, work_r[RampW-1:0]};

  // steer the shared unit by sequencer step
  always_comb begin
    op_a = item_r.time_now_ms;
    op_b = ramp_start_r;
    unique case (state_r)
      S_ELAP: begin
        op_a = item_r.time_now_ms;
        op_b = ramp_start_r;
      end
      S_RCMP: begin
        op_a = work_r;
        op_b = {16'b0, ramp_time_r};
      end
      S_DIV: begin
        op_a = {15'b0, rem_r, prod_r[cnt_r]};
        op_b = {16'b0, ramp_time_r};
      end
      S_LOWCMP: begin
        op_a = {24'b0, min_duty_r};
        op_b = {24'b0, duty_r};
      end
      S_SDIFF: begin
        op_a = item_r.time_now_ms;
        op_b = stamp_r;
      end
      S_SCMP: begin
        op_a = work_r;
        op_b = {16'b0, timeout_r};
      end
      default: begin
        op_a = item_r.time_now_ms;
        op_b = ramp_start_r;
      end
    endcase
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // configuration writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_time_r <= 16'd500;
      timeout_r   <= 16'd2000;
      min_duty_r  <= 8'd10;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RAMP_TIME:     ramp_time_r <= cfg_wdata;
        REG_STALL_TIMEOUT: timeout_r   <= cfg_wdata;
        REG_MIN_DUTY:      min_duty_r  <= cfg_wdata[DutyW-1:0];
        default: ;
      endcase
    end
  end

  // payload-only working registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_r  <= in_data;
          duty_r  <= '0;
          fault_r <= 1'b0;
        end
      end
      S_ELAP: work_r <= sub_diff;
      S_RCMP: begin
        if (item_r.target_duty == '0) begin
          duty_r <= '0;
        end else if (sub_ge) begin
          duty_r <= item_r.target_duty;
        end
      end
      S_MUL: begin
        // product < 256 * ramp time, so the top 16 bits start below the divisor
        prod_r <= mul_w[DutyW-1:0];
        rem_r  <= mul_w[23:8];
        quot_r <= '0;
        cnt_r  <= 3'd7;
      end
      S_DIV: begin
        if (sub_ge) begin
          rem_r <= sub_diff[RampW-1:0];
        end else begin
          rem_r <= op_a[RampW-1:0];
        end
        quot_r <= {quot_r[DutyW-2:0], sub_ge};
        cnt_r  <= cnt_r - 3'd1;
        if (cnt_r == 3'd0) begin
          duty_r <= {quot_r[DutyW-2:0], sub_ge};
        end
      end
      S_LOWCMP: fault_r <= 1'b0;
      S_SDIFF:  work_r  <= sub_diff;
      S_SCMP:   fault_r <= sub_ge;
      S_OUT: ;
      default: ;
    endcase
  end

  // sequencer, persistent state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      prev_dir_r   <= DIR_STOP;
      ramp_start_r <= '0;
      stamp_r      <= '0;
    end else begin
      // drop a taken result unless S_OUT replaces it on this edge
      if (out_valid_r && out_ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            // direction change restarts ramp and stall timing
            if (in_data.command_direction != prev_dir_r) begin
              ramp_start_r <= in_data.time_now_ms;
              prev_dir_r   <= in_data.command_direction;
            end
            // a stop or a direction change restamps the stall timer
            if (in_data.command_direction != prev_dir_r ||
                in_data.command_direction == DIR_STOP) begin
              stamp_r <= in_data.time_now_ms;
            end
            if (in_data.command_direction == DIR_STOP) begin
              state_r <= S_OUT;
            end else begin
              state_r <= S_ELAP;
            end
          end
        end
        S_ELAP: state_r <= S_RCMP;
        S_RCMP: begin
          if (item_r.target_duty == '0 || sub_ge) begin
            state_r <= S_LOWCMP;
          end else begin
            state_r <= S_MUL;
          end
        end
        S_MUL: state_r <= S_DIV;
        S_DIV: begin
          if (cnt_r == 3'd0) begin
            state_r <= S_LOWCMP;
          end
        end
        S_LOWCMP: begin
          if (sub_ge) begin
            // a zero stamp counts as not started
            if (stamp_r == '0) begin
              stamp_r <= item_r.time_now_ms;
            end
            state_r <= S_SDIFF;
          end else begin
            stamp_r <= item_r.time_now_ms;
            state_r <= S_OUT;
          end
        end
        S_SDIFF: state_r <= S_SCMP;
        S_SCMP:  state_r <= S_OUT;
        S_OUT: begin
          // hold until the previous result is taken
          if (!out_valid_r || out_ready) begin
            out_r.drive_direction <= item_r.command_direction;
            out_r.drive_duty      <= duty_r;
            out_r.stall_fault     <= fault_r;
            out_valid_r           <= 1'b1;
            state_r               <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sim/tb_soft_start_pwm_ramp_stall_detect.sv =====
// Self-checking testbench for soft_start_pwm_ramp_stall_detect: a directed table, then
// randomized ramp/stall sequences under several register settings, with a behavioral predictor.
// Depends on sspr_pkg and the RTL top level only.
module tb_soft_start_pwm_ramp_stall_detect;
  timeunit 1ns;
  timeprecision 1ps;

  import sspr_pkg::*;

  // Direction codes beyond stop; code three is driven like an active direction.
  localparam logic [DirW-1:0] DIR_UP   = 2'd1;
  localparam logic [DirW-1:0] DIR_DOWN = 2'd2;
  localparam logic [DirW-1:0] DIR_ODD  = 2'd3;

  localparam int RandPhases    = 6;
  localparam int ItemsPerPhase = 200;
  localparam int MaxReports    = 10;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_ready;
  out_item_t           out_data;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgW-1:0]     cfg_wdata;

  soft_start_pwm_ramp_stall_detect uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor copy of the registers and of the block's state.
  logic [RampW-1:0] ramp_ms;
  logic [RampW-1:0] stall_ms;
  logic [DutyW-1:0] min_duty;
  logic [DirW-1:0]  dir_prev;
  logic [TimeW-1:0] ramp_t0;
  logic [TimeW-1:0] quiet_t0;   // start of the current low-duty stretch

  out_item_t drive_q[$];        // predicted drive outputs, oldest first
  int        bad;               // mismatches plus unexpected results
  int        results_seen;
  int        burst_left;

  // Directed table: plain transactions, transactions with a pinned answer, register loads.
  typedef enum logic [1:0] {ROW_STEP, ROW_PINNED, ROW_REGS} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    in_item_t         item;
    out_item_t        want;
    logic [RampW-1:0] r_ramp;
    logic [RampW-1:0] r_stall;
    logic [DutyW-1:0] r_min;
  } plan_row_t;

  plan_row_t plan[$];

  function automatic plan_row_t step_row(logic [DirW-1:0] d, logic [DutyW-1:0] tgt,
                                         logic [TimeW-1:0] t);
    plan_row_t r;
    r.kind = ROW_STEP;
    r.item = '{command_direction: d, target_duty: tgt, time_now_ms: t};
    r.want = '0;
    r.r_ramp = '0;
    r.r_stall = '0;
    r.r_min = '0;
    return r;
  endfunction

  function automatic plan_row_t pinned_row(logic [DirW-1:0] d, logic [DutyW-1:0] tgt,
                                           logic [TimeW-1:0] t, logic [DutyW-1:0] duty,
                                           logic fault);
    plan_row_t r;
    r = step_row(d, tgt, t);
    r.kind = ROW_PINNED;
    r.want = '{drive_direction: d, drive_duty: duty, stall_fault: fault};
    return r;
  endfunction

  function automatic plan_row_t regs_row(logic [RampW-1:0] rt, logic [RampW-1:0] st,
                                         logic [DutyW-1:0] md);
    plan_row_t r;
    r = step_row(DIR_STOP, '0, '0);
    r.kind = ROW_REGS;
    r.r_ramp = rt;
    r.r_stall = st;
    r.r_min = md;
    return r;
  endfunction

  // Advance the predictor by one update and return the drive it calls for.
  function automatic out_item_t ramp_drive(in_item_t it);
    out_item_t        res;
    logic [TimeW-1:0] elapsed;
    logic [TimeW-1:0] quiet_for;
    logic [47:0]      prod;
    logic [DutyW-1:0] duty;
    logic             fault;
    duty = '0;
    fault = 1'b0;
    if (it.command_direction != dir_prev) begin
      ramp_t0 = it.time_now_ms;
      quiet_t0 = it.time_now_ms;
      dir_prev = it.command_direction;
    end
    if (it.command_direction == DIR_STOP) begin
      quiet_t0 = it.time_now_ms;
    end else begin
      elapsed = it.time_now_ms - ramp_t0;
      if (it.target_duty == '0) begin
        duty = '0;
      end else if (elapsed >= {16'h0000, ramp_ms}) begin
        duty = it.target_duty;
      end else begin
        // elapsed < ramp_ms here, so the divisor is nonzero and the quotient fits 8 bits
        prod = 48'(it.target_duty) * 48'(elapsed);
        duty = DutyW'(prod / 48'(ramp_ms));
      end
      if (duty <= min_duty) begin
        // a zero stamp reads as "not started yet"
        if (quiet_t0 == '0) quiet_t0 = it.time_now_ms;
        quiet_for = it.time_now_ms - quiet_t0;
        fault = (quiet_for >= {16'h0000, stall_ms});
      end else begin
        quiet_t0 = it.time_now_ms;
      end
    end
    res.drive_direction = it.command_direction;
    res.drive_duty = duty;
    res.stall_fault = fault;
    return res;
  endfunction

  // Offer one transaction; drop valid for a random gap whenever a burst runs out.
  // The expectation is logged at the accepting edge.
  task automatic offer(input in_item_t it, input logic pinned, input out_item_t want);
    out_item_t calc;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    calc = ramp_drive(it);
    drive_q.push_back(pinned ? want : calc);
    burst_left--;
  endtask

  // Drop valid and wait for the block to drain before touching the registers.
  task automatic settle();
    in_valid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Load all three registers on consecutive edges; cfg_we is raised once for all three and then lowered.
  task automatic load_regs(input logic [RampW-1:0] rt, input logic [RampW-1:0] st,
                           input logic [DutyW-1:0] md);
    cfg_we <= 1'b1;
    cfg_index <= REG_RAMP_TIME;
    cfg_wdata <= rt;
    @(posedge clk);
    cfg_index <= REG_STALL_TIMEOUT;
    cfg_wdata <= st;
    @(posedge clk);
    cfg_index <= REG_MIN_DUTY;
    cfg_wdata <= CfgW'(md);
    @(posedge clk);
    cfg_we <= 1'b0;
    ramp_ms = rt;
    stall_ms = st;
    min_duty = md;
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: rotate through ready patterns, and once, after a few hundred results,
  // hold off for a long stretch so the block backs up and stalls its input.
  initial begin
    int  mode;
    int  mode_left;
    int  hold_left;
    bit  long_hold_done;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    long_hold_done = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!long_hold_done && results_seen >= 300) begin
        hold_left = 400;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (mode)
          0: out_ready <= 1'b1;                            // no back-pressure
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);     // heavy stalling
          default: out_ready <= (mode_left % 5) != 0;      // periodic single-cycle stalls
        endcase
      end
    end
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin
    out_item_t exp_item;
    if (rst_n && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (drive_q.size() == 0) begin
        if (bad < MaxReports)
          $display("unexpected result at %0t: dir %0d duty %0d fault %0d", $realtime,
                   out_data.drive_direction, out_data.drive_duty, out_data.stall_fault);
        bad <= bad + 1;
      end else begin
        exp_item = drive_q.pop_front();
        if (out_data.drive_direction !== exp_item.drive_direction ||
            out_data.drive_duty !== exp_item.drive_duty ||
            out_data.stall_fault !== exp_item.stall_fault) begin
          if (bad < MaxReports)
            $display("mismatch at %0t: expected dir/duty/fault %0d/%0d/%0d, got %0d/%0d/%0d",
                     $realtime, exp_item.drive_direction, exp_item.drive_duty,
                     exp_item.stall_fault, out_data.drive_direction, out_data.drive_duty,
                     out_data.stall_fault);
          bad <= bad + 1;
        end
      end
    end
  end

  // Stimulus: directed table first, then randomized phases under fresh register settings.
  initial begin
    plan_row_t        row;
    in_item_t         it;
    out_item_t        blank;
    logic [DirW-1:0]  dir;
    logic [DutyW-1:0] tgt;
    logic [TimeW-1:0] clock_ms;
    logic [RampW-1:0] r_ramp;
    logic [RampW-1:0] r_stall;
    logic [DutyW-1:0] r_min;
    int               lo_cap;

    bad = 0;
    results_seen = 0;
    burst_left = 0;
    blank = '0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_RAMP_TIME;
    cfg_wdata <= '0;

    // Reset defaults: 500 ms ramp, 2000 ms timeout, minimum duty 10, stamps cleared.
    ramp_ms = 16'd500;
    stall_ms = 16'd2000;
    min_duty = 8'd10;
    dir_prev = DIR_STOP;
    ramp_t0 = '0;
    quiet_t0 = '0;

    // Stop with a nonzero target, a zero target, then a full ramp up and a partial one.
    plan.push_back(pinned_row(DIR_STOP, 8'd255, 32'd100, 8'd0, 1'b0));
    plan.push_back(pinned_row(DIR_UP, 8'd0, 32'd200, 8'd0, 1'b0));
    plan.push_back(pinned_row(DIR_UP, 8'd255, 32'd700, 8'd255, 1'b0));
    plan.push_back(step_row(DIR_UP, 8'd255, 32'd450));
    // Reverse, reach target, then drop to a low duty long enough to fault.
    plan.push_back(pinned_row(DIR_DOWN, 8'd200, 32'd1000, 8'd0, 1'b0));
    plan.push_back(step_row(DIR_DOWN, 8'd200, 32'd3000));
    plan.push_back(pinned_row(DIR_DOWN, 8'd5, 32'd6000, 8'd5, 1'b1));
    // Direction code three, with the clock wrapping past all ones.
    plan.push_back(pinned_row(DIR_ODD, 8'd255, 32'hFFFF_FFFF, 8'd0, 1'b0));
    plan.push_back(step_row(DIR_ODD, 8'd255, 32'd0));
    plan.push_back(step_row(DIR_ODD, 8'd255, 32'd498));
    // Stamps at time zero: read as not started and restamped on the next low duty.
    plan.push_back(pinned_row(DIR_STOP, 8'd0, 32'd0, 8'd0, 1'b0));
    plan.push_back(pinned_row(DIR_UP, 8'd255, 32'd0, 8'd0, 1'b0));
    plan.push_back(step_row(DIR_UP, 8'd20, 32'd100));
    plan.push_back(step_row(DIR_UP, 8'd20, 32'd2100));
    // Duty exactly at the minimum, timeout reached exactly, then time stepping back.
    plan.push_back(pinned_row(DIR_UP, 8'd10, 32'd4100, 8'd10, 1'b1));
    plan.push_back(step_row(DIR_UP, 8'd10, 32'd4099));
    // Zero ramp time gives full target at once; zero timeout faults immediately.
    plan.push_back(regs_row(16'd0, 16'd0, 8'd255));
    plan.push_back(pinned_row(DIR_DOWN, 8'd1, 32'd5000, 8'd1, 1'b1));
    plan.push_back(pinned_row(DIR_DOWN, 8'd255, 32'd5001, 8'd255, 1'b1));
    // Largest ramp and timeout, minimum duty zero.
    plan.push_back(regs_row(16'hFFFF, 16'hFFFF, 8'd0));
    plan.push_back(pinned_row(DIR_UP, 8'd255, 32'd10, 8'd0, 1'b0));
    plan.push_back(step_row(DIR_UP, 8'd255, 32'd65544));
    plan.push_back(pinned_row(DIR_UP, 8'd255, 32'd65545, 8'd255, 1'b0));
    plan.push_back(pinned_row(DIR_UP, 8'd0, 32'd200000, 8'd0, 1'b1));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_REGS) begin
        settle();
        load_regs(row.r_ramp, row.r_stall, row.r_min);
      end else begin
        offer(row.item, row.kind == ROW_PINNED, row.want);
      end
    end

    // Random part: mostly coherent ramps (sticky direction and target, time moving
    // forward at ramp and timeout scales), with jumps, small rewinds and clock wrap.
    dir = dir_prev;
    tgt = 8'd128;
    clock_ms = 32'd300000;
    for (int p = 0; p < RandPhases; p++) begin
      settle();
      case ($urandom_range(0, 5))
        0: r_ramp = 16'd0;
        1: r_ramp = 16'd1;
        2: r_ramp = 16'hFFFF;
        default: r_ramp = RampW'($urandom_range(2, 3000));
      endcase
      case ($urandom_range(0, 4))
        0: r_stall = 16'd0;
        1: r_stall = 16'hFFFF;
        default: r_stall = RampW'($urandom_range(1, 4000));
      endcase
      case ($urandom_range(0, 4))
        0: r_min = 8'd0;
        1: r_min = 8'd255;
        default: r_min = DutyW'($urandom_range(0, 60));
      endcase
      load_regs(r_ramp, r_stall, r_min);

      for (int n = 0; n < ItemsPerPhase; n++) begin
        case ($urandom_range(0, 11))
          0: clock_ms = $urandom;
          1: clock_ms = clock_ms - TimeW'($urandom_range(0, 64));
          2: clock_ms = 32'hFFFF_FFFF - TimeW'($urandom_range(0, 2000));
          3, 4, 5, 6: clock_ms = clock_ms + TimeW'($urandom_range(0, int'(ramp_ms) / 8 + 3));
          7, 8, 9: clock_ms = clock_ms + TimeW'($urandom_range(0, int'(stall_ms) / 2 + 3));
          default: clock_ms = clock_ms + TimeW'($urandom_range(0, 3));
        endcase
        if ($urandom_range(0, 11) == 0) dir = DirW'($urandom_range(0, 3));
        if ($urandom_range(0, 3) == 0) begin
          lo_cap = int'(min_duty) + 4;
          if (lo_cap > 255) lo_cap = 255;
          case ($urandom_range(0, 5))
            0: tgt = 8'd0;
            1: tgt = 8'd255;
            2: tgt = DutyW'($urandom_range(0, lo_cap));
            default: tgt = DutyW'($urandom_range(0, 255));
          endcase
        end
        it = '{command_direction: dir, target_duty: tgt, time_now_ms: clock_ms};
        offer(it, 1'b0, blank);
      end
    end

    // Drain, then give the block a few idle cycles to show any stray result.
    in_valid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (bad == 0 && drive_q.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
